// ===== rtl/tdes_pkg.sv =====
// shared types, tables and functions for the two-key triple des unit
`default_nettype none
package tdes_pkg;

    localparam int BlockWidth = 64;
    localparam int KeyWidth   = 64;
    localparam int SubkeyWidth = 48;
    localparam int NumRounds  = 16;
    localparam int NumPasses  = 3;
    localparam int TotalRounds = NumRounds * NumPasses;
    localparam int CfgIndexWidth = 1;

    typedef logic [CfgIndexWidth-1:0] cfg_index_t;
    localparam cfg_index_t RegKeyOne = 1'b0;
    localparam cfg_index_t RegKeyTwo = 1'b1;

    typedef logic [SubkeyWidth-1:0] subkey_t;
    typedef subkey_t [NumRounds-1:0] sched_t;

    // per-stage payload: round halves and direction
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        enc;
    } round_data_t;

    typedef logic [7:0] idx_t;

    localparam idx_t TabIp [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam idx_t TabFp [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam idx_t TabE [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam idx_t TabP [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam idx_t TabPc1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam idx_t TabPc2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [1:0] TabShift [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // initial permutation, des bit 1 is the msb
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
        return r;
    endfunction

    // des round function
    function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TabE[i])];
        x = x ^ k;
        for (int b = 0; b < 8; b++) begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = TabS[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
        return p;
    endfunction

    // full key schedule, fixed wiring only
    function automatic sched_t expand_key(input logic [63:0] key);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] m;
        sched_t      rk;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(TabPc1[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int j = 0; j < 16; j++) begin
            if (TabShift[j] == 2'd1) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end else begin
                c = {c[25:0], c[27:26]};
                d = {d[25:0], d[27:26]};
            end
            m = {c, d};
            for (int i = 0; i < 48; i++) rk[j][47-i] = m[56-int'(TabPc2[i])];
        end
        return rk;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/triple_des_ede_two_key_unit.sv =====
// top level of the two-key triple des ecb engine
`default_nettype none
// Two-key triple DES (EDE encrypt, DED decrypt) in ECB mode. One block enters
// per cycle when the output is not stalled: the 48 DES rounds are unrolled
// into 48 register stages, followed by one output register. A stall on
// m_axis_tready holds the whole pipeline; a beat can still enter while the
// output register is empty or being taken. Key writes re-expand the round
// keys in the next cycle and should be done while the pipeline is empty.
module triple_des_ede_two_key_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // block_in [63:0]
    input  wire         s_axis_tuser,   // do_encrypt
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // block_out [63:0]
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire  [63:0] cfg_wr_data
);
    import tdes_pkg::*;

    sched_t sched_one_reg;
    sched_t sched_two_reg;

    // key expansion on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_one_reg <= '0;
            sched_two_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                RegKeyOne: sched_one_reg <= expand_key(cfg_wr_data);
                RegKeyTwo: sched_two_reg <= expand_key(cfg_wr_data);
                default: ;
            endcase
        end
    end

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        advance;
    logic        stage_valid [TotalRounds+1];
    round_data_t stage_data  [TotalRounds+1];
    logic [63:0] ip_block;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // initial permutation into the first stage
    always_comb begin
        ip_block             = perm_ip(s_axis_tdata);
        stage_valid[0]       = s_axis_tvalid;
        stage_data[0].left   = ip_block[63:32];
        stage_data[0].right  = ip_block[31:0];
        stage_data[0].enc    = s_axis_tuser;
    end

    // 48 round stages; inner ip/fp cancel, only the half swap remains
    for (genvar g = 0; g < TotalRounds; g++) begin : g_round
        localparam int Pass = g / NumRounds;
        localparam int Rnd  = g % NumRounds;
        round_data_t stage_in;
        subkey_t     k_fwd;
        subkey_t     k_rev;
        always_comb begin
            stage_in = stage_data[g];
            if (Rnd == 0 && Pass != 0) begin
                stage_in.left  = stage_data[g].right;
                stage_in.right = stage_data[g].left;
            end
            if (Pass == 1) begin
                // middle pass runs the opposite direction
                k_fwd = sched_two_reg[NumRounds-1-Rnd];
                k_rev = sched_two_reg[Rnd];
            end else begin
                k_fwd = sched_one_reg[Rnd];
                k_rev = sched_one_reg[NumRounds-1-Rnd];
            end
        end
        tdes_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .valid_in  (stage_valid[g]),
            .data_in   (stage_in),
            .key_enc   (k_fwd),
            .key_dec   (k_rev),
            .valid_out (stage_valid[g+1]),
            .data_out  (stage_data[g+1])
        );
    end

    // final permutation into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= stage_valid[TotalRounds];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= perm_fp({stage_data[TotalRounds].right,
                                     stage_data[TotalRounds].left});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");
    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stage_valid[TotalRounds] |=> m_axis_tvalid)
        else $error("finished beat lost at output register");
`endif
endmodule
`default_nettype wire

// ===== rtl/tdes_round.sv =====
// one registered des round stage with stall control
`default_nettype none
module tdes_round (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     advance,
    input  wire                     valid_in,
    input  tdes_pkg::round_data_t   data_in,
    input  tdes_pkg::subkey_t       key_enc,
    input  tdes_pkg::subkey_t       key_dec,
    output logic                    valid_out,
    output tdes_pkg::round_data_t   data_out
);
    import tdes_pkg::*;

    logic        valid_reg;
    round_data_t data_reg;
    round_data_t data_next;

    // round: swap halves, mix right through f
    always_comb begin
        data_next.enc   = data_in.enc;
        data_next.left  = data_in.right;
        data_next.right = data_in.left ^
            feistel(data_in.right, data_in.enc ? key_enc : key_dec);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule
`default_nettype wire
